>>> hw/rtl/first_fit_heap_allocator_unit_macros.svh
// assertion helpers for the allocator
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

>>> hw/rtl/ffha_pkg.sv
package ffha_pkg;
	localparam int MAX_ENTRIES_DEF  = 64;
	localparam int HEADER_BYTES_DEF = 12;
	localparam int SPLIT_SLACK      = 8;
	localparam logic [32:0] ALIGN_MASK  = 33'd3;
	localparam logic [31:0] PAGE_MASK   = 32'hFFF;
	localparam logic [31:0] LIMIT_RESET = 32'h0100_0000;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_ZERO        = 3'd1;
	localparam logic [2:0] ST_OUT_OF_HEAP = 3'd2;
	localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
	localparam logic [2:0] ST_REL_IGNORED = 3'd4;

	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		W_USED, W_FREE, W_SHIFT, W_SPLIT_A, W_SPLIT_B, W_APPEND
	} wsrc_t;

	typedef enum logic [1:0] {G_NONE, G_RD, G_HIT, G_TOP} gsrc_t;

	typedef struct packed {
		logic       load;
		logic       idx_inc;
		logic       rd_shift;
		logic       hit_cap;
		logic       j_dec;
		logic       mem_we;
		wsrc_t      wsrc;
		logic       cnt_inc;
		logic       top_adv;
		logic       res_we;
		logic [2:0] res_status;
		gsrc_t      gsrc;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic zero_req;
		logic zero_addr;
		logic idx_end;
		logic fit;
		logic split_ok;
		logic match;
		logic shift_more;
		logic limit_fail;
		logic full;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic        free;
	} entry_t;
endpackage

>>> hw/rtl/ffha_ctrl.sv
module ffha_ctrl import ffha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_START, S_SCAN_RD, S_SCAN_CHK, S_SHIFT_TEST, S_SHIFT_RD,
		S_SHIFT_WR, S_SPLIT_A, S_SPLIT_B, S_APPEND, S_FINISH
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.wsrc = W_USED;
		cmd.gsrc = G_NONE;
		cmd.res_status = ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_START;
				end
			end
			S_START: begin
				if (sts.mode && sts.zero_addr) begin
					cmd.res_we = 1'b1;
					cmd.res_status = ST_REL_IGNORED;
					state_d = S_FINISH;
				end else if (!sts.mode && sts.zero_req) begin
					cmd.res_we = 1'b1;
					cmd.res_status = ST_ZERO;
					state_d = S_FINISH;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (!sts.idx_end) state_d = S_SCAN_CHK;
				else if (!sts.mode) state_d = S_APPEND;
				else begin
					cmd.res_we = 1'b1;
					cmd.res_status = ST_REL_IGNORED;
					state_d = S_FINISH;
				end
			end
			S_SCAN_CHK: begin
				if (!sts.mode && sts.fit) begin
					if (sts.split_ok) begin
						cmd.hit_cap = 1'b1;
						state_d = S_SHIFT_TEST;
					end else begin
						cmd.mem_we = 1'b1;
						cmd.wsrc = W_USED;
						cmd.res_we = 1'b1;
						cmd.gsrc = G_RD;
						state_d = S_FINISH;
					end
				end else if (sts.mode && sts.match) begin
					cmd.mem_we = 1'b1;
					cmd.wsrc = W_FREE;
					cmd.res_we = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = S_SCAN_RD;
				end
			end
			S_SHIFT_TEST: state_d = sts.shift_more ? S_SHIFT_RD : S_SPLIT_A;
			S_SHIFT_RD: begin
				cmd.rd_shift = 1'b1;
				state_d = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				cmd.mem_we = 1'b1;
				cmd.wsrc = W_SHIFT;
				cmd.j_dec = 1'b1;
				state_d = S_SHIFT_TEST;
			end
			S_SPLIT_A: begin
				cmd.mem_we = 1'b1;
				cmd.wsrc = W_SPLIT_A;
				state_d = S_SPLIT_B;
			end
			S_SPLIT_B: begin
				cmd.mem_we = 1'b1;
				cmd.wsrc = W_SPLIT_B;
				cmd.cnt_inc = 1'b1;
				cmd.res_we = 1'b1;
				cmd.gsrc = G_HIT;
				state_d = S_FINISH;
			end
			S_APPEND: begin
				cmd.res_we = 1'b1;
				if (sts.limit_fail) cmd.res_status = ST_OUT_OF_HEAP;
				else if (sts.full) cmd.res_status = ST_TABLE_FULL;
				else begin
					cmd.mem_we = 1'b1;
					cmd.wsrc = W_APPEND;
					cmd.cnt_inc = 1'b1;
					cmd.top_adv = 1'b1;
					cmd.gsrc = G_TOP;
				end
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

>>> hw/rtl/ffha_dpath.sv
module ffha_dpath import ffha_pkg::*; #(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        in_mode,
	input  logic [31:0] in_size,
	input  logic [31:0] in_addr,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_addr,
	output logic [2:0]  out_status
);
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [31:0] H32 = 32'(HEADER_BYTES);

	entry_t mem_q [MAX_ENTRIES];
	entry_t rd_q, wd;
	logic [IW-1:0] wa, ra;

	logic        mode_q;
	logic [31:0] req_q, addr_q, limit_q, top_q;
	logic [32:0] need_q;
	logic [CW-1:0] idx_q, j_q, cnt_q;
	logic [IW-1:0] hit_q;
	logic [31:0] hit_start_q, hit_size_q;
	logic [2:0]  res_status_q;
	logic [31:0] res_addr_q;
	logic        out_valid_q;
	logic [31:0] res_addr_d;
	logic [CW:0] hit_ext;

	assign hit_ext = {{(CW + 1 - IW){1'b0}}, hit_q};

	assign sts.mode       = mode_q;
	assign sts.zero_req   = (req_q == 32'd0);
	assign sts.zero_addr  = (addr_q == 32'd0);
	assign sts.idx_end    = (idx_q == cnt_q);
	assign sts.fit        = rd_q.free && ({1'b0, rd_q.size} >= need_q);
	assign sts.split_ok   = ({2'b0, rd_q.size} >= {1'b0, need_q} + 34'(HEADER_BYTES)
		+ 34'(SPLIT_SLACK)) && (cnt_q < CW'(MAX_ENTRIES));
	assign sts.match      = (rd_q.start + H32 == addr_q);
	assign sts.shift_more = ({1'b0, j_q} > hit_ext + (CW + 1)'(1));
	assign sts.limit_fail = ({2'b0, top_q} + 34'(HEADER_BYTES) + {1'b0, need_q})
		> {2'b0, limit_q};
	assign sts.full       = (cnt_q >= CW'(MAX_ENTRIES));
	assign sts.out_free   = !out_valid_q || out_ready;

	assign ra = cmd.rd_shift ? IW'(j_q - CW'(1)) : idx_q[IW-1:0];

	always_comb begin
		wa = idx_q[IW-1:0];
		wd = rd_q;
		unique case (cmd.wsrc)
			W_USED: begin
				wd.free = 1'b0;
			end
			W_FREE: begin
				wd.free = 1'b1;
			end
			W_SHIFT: begin
				wa = j_q[IW-1:0];
			end
			W_SPLIT_A: begin
				wa = hit_q;
				wd = '{start: hit_start_q, size: need_q[31:0], free: 1'b0};
			end
			W_SPLIT_B: begin
				wa = hit_q + IW'(1);
				wd = '{start: hit_start_q + H32 + need_q[31:0],
					size: hit_size_q - need_q[31:0] - H32, free: 1'b1};
			end
			W_APPEND: begin
				wa = cnt_q[IW-1:0];
				wd = '{start: top_q, size: need_q[31:0], free: 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) mem_q[wa] <= wd;
		rd_q <= mem_q[ra];
	end

	always_comb begin
		unique case (cmd.gsrc)
			G_RD:    res_addr_d = rd_q.start + H32;
			G_HIT:   res_addr_d = hit_start_q + H32;
			G_TOP:   res_addr_d = top_q + H32;
			default: res_addr_d = 32'd0;
		endcase
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			req_q  <= in_size;
			addr_q <= in_addr;
			need_q <= ({1'b0, in_size} + ALIGN_MASK) & ~ALIGN_MASK;
		end
		if (cmd.hit_cap) begin
			hit_q       <= idx_q[IW-1:0];
			hit_start_q <= rd_q.start;
			hit_size_q  <= rd_q.size;
		end
		if (cmd.res_we) begin
			res_status_q <= cmd.res_status;
			res_addr_q   <= res_addr_d;
		end
		if (cmd.out_load) begin
			out_status <= res_status_q;
			out_addr   <= res_addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
			limit_q <= LIMIT_RESET;
			top_q <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + CW'(1);
			if (cmd.hit_cap) j_q <= cnt_q;
			else if (cmd.j_dec) j_q <= j_q - CW'(1);
			if (cmd.top_adv) top_q <= top_q + H32 + need_q[31:0];
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			if (cfg_we && cfg_index == REG_HEAP_BASE) begin
				top_q  <= (cfg_data + PAGE_MASK) & ~PAGE_MASK;
				cnt_q  <= '0;
			end
			if (cfg_we && cfg_index == REG_HEAP_LIMIT) limit_q <= cfg_data;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
endmodule

>>> hw/rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator. One request per transfer on the s_ side gives one
// result transfer on the m_ side. The block table sits in a memory with one
// write port and one registered read port, so the scan reads and then checks
// each table entry in turn. An allocate stops at the first entry that fits;
// on a split it moves every later entry up by one (shift test, read, write),
// then does the final shift test and the two split writes. An append scans
// the whole table first. One request is in work at a time; the input is taken
// again once the result is in the output register. Writing heap_base empties
// the table and moves the heap end to the base rounded up to 4 KB. No clearing
// pass is needed after reset.
`include "first_fit_heap_allocator_unit_macros.svh"
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // request_size[31:0], release_address[63:32]
	input  logic [0:0]  s_tuser,  // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // granted_address[31:0], status[34:32], zero fill
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic [31:0] out_addr;
	logic [2:0]  out_status;

	ffha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.sts(sts), .cmd(cmd)
	);

	ffha_dpath #(.MAX_ENTRIES(MAX_ENTRIES), .HEADER_BYTES(HEADER_BYTES)) u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_mode(s_tuser[0]), .in_size(s_tdata[31:0]), .in_addr(s_tdata[63:32]),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_addr(out_addr), .out_status(out_status)
	);

	assign m_tdata = {5'd0, out_status, out_addr};

	// one request in flight
	`FFHA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// only an ok allocate carries an address
	`FFHA_ASSERT_NOW(a_addr_on_ok, m_tvalid && m_tdata[34:32] != ST_OK, m_tdata[31:0] == 32'd0)
	// status codes stay in range
	`FFHA_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[34:32] <= ST_REL_IGNORED)
endmodule

>>> verif/ffha_checker.sv
`timescale 1ns / 1ps

// Watches the allocator channels, keeps its own copy of the block table and
// compares every result transfer with the oldest outstanding expectation.
module ffha_checker import ffha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);
	localparam int NENT = MAX_ENTRIES_DEF;
	localparam int HDR  = HEADER_BYTES_DEF;

	typedef struct {
		logic [31:0] addr;
		logic [2:0]  status;
	} grant_t;

	logic [31:0] limit_q, top_q;
	logic [31:0] blk_start [NENT];
	logic [31:0] blk_size  [NENT];
	logic        blk_free  [NENT];
	int          blk_count;
	grant_t      grants_due [$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: %s got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	// allocation: first fit over the table, split when slack and a free table slot allow, else append
	function automatic grant_t allocate(input logic [31:0] req);
		grant_t      g;
		logic [32:0] need;
		logic [33:0] end_addr;
		g.addr   = '0;
		g.status = ST_OK;
		if (req == 0) begin
			g.status = ST_ZERO;
			return g;
		end
		need = ({1'b0, req} + 33'd3) & ~33'd3;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_free[i] && {1'b0, blk_size[i]} >= need) begin
				blk_free[i] = 1'b0;
				if ({2'b0, blk_size[i]} >= {1'b0, need} + HDR + SPLIT_SLACK
						&& blk_count < NENT) begin
					for (int j = blk_count; j > i + 1; j--) begin
						blk_start[j] = blk_start[j-1];
						blk_size[j]  = blk_size[j-1];
						blk_free[j]  = blk_free[j-1];
					end
					blk_start[i+1] = blk_start[i] + HDR + need[31:0];
					blk_size[i+1]  = blk_size[i] - need[31:0] - HDR;
					blk_free[i+1]  = 1'b1;
					blk_size[i]    = need[31:0];
					blk_count++;
				end
				g.addr = blk_start[i] + HDR;
				return g;
			end
		end
		end_addr = {2'b0, top_q} + HDR + {1'b0, need};
		if (end_addr > {2'b0, limit_q}) begin
			g.status = ST_OUT_OF_HEAP;
			return g;
		end
		if (blk_count >= NENT) begin
			g.status = ST_TABLE_FULL;
			return g;
		end
		blk_start[blk_count] = top_q;
		blk_size[blk_count]  = need[31:0];
		blk_free[blk_count]  = 1'b0;
		blk_count++;
		g.addr = top_q + HDR;
		top_q  = top_q + HDR + need[31:0];
		return g;
	endfunction

	function automatic grant_t release_block(input logic [31:0] addr);
		grant_t g;
		g.addr   = '0;
		g.status = ST_REL_IGNORED;
		if (addr == 0)
			return g;
		for (int i = 0; i < blk_count; i++) begin
			if (blk_start[i] + HDR == addr) begin
				blk_free[i] = 1'b1;
				g.status    = ST_OK;
				return g;
			end
		end
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			limit_q   = LIMIT_RESET;
			top_q     = '0;
			blk_count = 0;
			errors    = 0;
			grants_due.delete();
			pending   = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_HEAP_BASE) begin
					top_q     = (cfg_data + PAGE_MASK) & ~PAGE_MASK;
					blk_count = 0;
				end else begin
					limit_q = cfg_data;
				end
			end
			if (m_tvalid && m_tready) begin
				if (grants_due.size() == 0) begin
					report("unexpected result, address", m_tdata[31:0], '0);
				end else begin
					want = grants_due.pop_front();
					if (m_tdata[31:0] !== want.addr)
						report("granted address", m_tdata[31:0], want.addr);
					if (m_tdata[34:32] !== want.status)
						report("status", {29'b0, m_tdata[34:32]}, {29'b0, want.status});
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0])
					grants_due.push_back(release_block(s_tdata[63:32]));
				else
					grants_due.push_back(allocate(s_tdata[31:0]));
			end
			pending = grants_due.size();
		end
	end
endmodule

>>> verif/tb_first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the allocator; result checking is in ffha_checker.
module tb_first_fit_heap_allocator_unit;
	import ffha_pkg::*;

	localparam int ITEM_TARGET = 1250;
	// slowest item: sender gap + allocator work + receiver stall, with margin
	localparam int IDLE_LIMIT  = 3000;
	localparam int TAIL_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;  // request_size[31:0], release_address[63:32]
	logic [0:0]  s_tuser = '0;  // mode[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;       // granted_address[31:0], status[34:32], zero fill
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	int          errors, pending;
	int          items_sent = 0;
	int          idle_cycles = 0;
	bit          no_gaps = 1'b0;  // stretches where neither side idles
	logic [31:0] live_addrs [$];  // addresses handed out in the current heap

	always #6 clk = ~clk;

	first_fit_heap_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ffha_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 18);
	endfunction

	// one request transfer; returns at the accepting edge with tvalid still high
	task automatic send(input logic mode, input logic [31:0] size, input logic [31:0] addr);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {addr, size};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// drop tvalid and wait until every result transfer has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// block is idle here; base write empties the table
	task automatic set_heap(input logic [31:0] base, input logic [31:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEAP_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= REG_HEAP_LIMIT;
		cfg_data  <= limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		live_addrs.delete();
	endtask

	function automatic logic [31:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)  return '0;
		if (r < 6)  return $urandom;
		if (r < 8)  return 32'hFFFF_FFFF - $urandom_range(0, 3);
		if (r < 75) return $urandom_range(1, 64);
		return $urandom_range(65, 4096);
	endfunction

	function automatic logic [31:0] pick_release();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75 && live_addrs.size() != 0)
			return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
		if (r < 85) return '0;
		return $urandom;
	endfunction

	// receiver: random stall before each result
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// harvest granted addresses for later releases
	always @(posedge clk) begin
		if (m_tvalid && m_tready && m_tdata[34:32] == ST_OK && m_tdata[31:0] != 0) begin
			live_addrs.push_back(m_tdata[31:0]);
			if (live_addrs.size() > 128)
				void'(live_addrs.pop_front());
		end
	end

	// watchdog: cycles without any transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int          phase_len;
		int          alloc_pct;
		logic [31:0] base, limit;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset heap (base 0, default limit)
		send(1'b0, 32'd0, 32'd0);            // zero size
		send(1'b0, 32'd1, 32'hFFFF_FFFF);    // rounds to 4
		send(1'b0, 32'd40, 32'd0);
		send(1'b0, 32'hFFFF_FFFF, 32'd0);    // rounds to 2^32
		send(1'b0, 32'hFFFF_FFFD, 32'd0);
		send(1'b1, 32'hFFFF_FFFF, 32'd0);    // release of zero
		send(1'b1, 32'd0, 32'hFFFF_FFFF);    // unknown address
		drain();
		send(1'b1, 32'd0, live_addrs[$]);    // free the 40-byte block
		send(1'b1, 32'd0, live_addrs[$]);    // already free
		send(1'b0, 32'd8, 32'd0);            // reuse with split
		send(1'b0, 32'd16, 32'd0);           // remainder fits, too small to split
		send(1'b0, 32'h00FF_FFF0, 32'd0);    // beyond limit
		drain();
		set_heap(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // base wraps to 0
		send(1'b1, 32'd0, 32'd12);           // empty table
		send(1'b0, 32'hFFFF_FFF0, 32'd0);    // fills up to the limit
		send(1'b0, 32'd4, 32'd0);
		drain();
		set_heap(32'hFFFF_F000, 32'd0);
		send(1'b0, 32'd4, 32'd0);
		drain();
		set_heap(32'hFFFF_F000, 32'hFFFF_FFFF);
		send(1'b0, 32'h0000_0FF4, 32'd0);    // end lands exactly on 2^32
		send(1'b0, 32'h0000_0FF0, 32'd0);
		send(1'b1, 32'd0, 32'hFFFF_F00C);
		drain();

		// random phases, each on a fresh heap
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 5))
				0: base = '0;
				1: base = 32'hFFFF_F000;
				2: base = 32'hFFFF_FFFF;
				3: base = $urandom_range(0, 32'h0010_0000);
				default: base = $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: limit = 32'hFFFF_FFFF;
				1: limit = LIMIT_RESET;
				2: limit = '0;
				3: limit = $urandom;
				default: limit = ((base + PAGE_MASK) & ~PAGE_MASK) + $urandom_range(0, 16384);
			endcase
			set_heap(base, limit);
			no_gaps   = ($urandom_range(0, 3) == 0);
			alloc_pct = $urandom_range(50, 95);
			phase_len = $urandom_range(40, 160);
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < alloc_pct)
					send(1'b0, pick_size(), $urandom);
				else
					send(1'b1, $urandom, pick_release());
			end
			drain();
		end

		no_gaps = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
